/* hdl/bss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants of the bounded sorted set
// Holds the request and response payload types, the action and status codes,
// the default build parameters, the limit settings and the controller types.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_KEY_BITS  = 16;
    localparam int DEF_RANK_BITS = 32;

    localparam int LIMIT_W     = 5;
    localparam int LIMIT_RESET = 16;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_FIND   = 3'd2,
        ACT_GET    = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [15:0]        key;
        logic signed [31:0] rank;
        logic [3:0]         offset;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         position;
        logic [15:0]        out_key;
        logic signed [31:0] out_rank;
        logic [4:0]         count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic step1;
        logic step2;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_add;
    } sts_t;

endpackage
`default_nettype wire

/* hdl/bounded_sorted_set.sv */
`default_nettype none
// A request is captured, runs the removal phase, the insertion phase for an add,
// and is then loaded into the response register; the controller takes no new
// request until it has loaded the response of the last one.
// A waiting response that is not taken holds the controller and so the request side.
// Reset (rst_n, asynchronous, active low) empties the list and sets the limit to 16;
// entry contents are not cleared and are never read beyond the count.
// ----------------------------------------------------------------------------
// bounded_sorted_set: bounded list of key and rank entries kept sorted by rank
// Supports add with duplicate removal and top-N replacement, delete by key,
// find by rank, get by position and clear. Every request gives one response.
// ----------------------------------------------------------------------------
module bounded_sorted_set #(
    parameter int CAPACITY  = bss_pkg::DEF_CAPACITY,
    parameter int KEY_BITS  = bss_pkg::DEF_KEY_BITS,
    parameter int RANK_BITS = bss_pkg::DEF_RANK_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire bss_pkg::req_t               req_data,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output bss_pkg::rsp_t                    rsp_data,
    input  wire logic                        cfg_we,
    input  wire logic [bss_pkg::LIMIT_W-1:0] cfg_data
);
    import bss_pkg::*;

    // The controller and datapath talk only through these two groups.
    cmd_t cmd;
    sts_t sts;

    // The controller owns both handshakes: it takes a request only when idle,
    // runs the removal phase, the insertion phase for adds, and then parks
    // the result until the response register is free.
    bss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath keeps the entries in a row of cells, each with its own
    // key and rank compare.
    bss_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_BITS  (KEY_BITS),
        .RANK_BITS (RANK_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .rsp_data (rsp_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
`default_nettype wire

/* hdl/bss_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bss_ctrl: sequencer of the bounded sorted set
// Steps each request through its datapath phases and owns both handshakes.
// ----------------------------------------------------------------------------
module bss_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    input  wire bss_pkg::sts_t sts,
    output bss_pkg::cmd_t      cmd
);
    import bss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_STEP1 = 4'b0010,
        S_STEP2 = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_STEP1;
                end
            end
            S_STEP1:
            begin
                cmd.step1  = 1'b1;
                state_next = sts.is_add ? S_STEP2 : S_DONE;
            end
            S_STEP2:
            begin
                cmd.step2  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Wait until the output register is free or being emptied.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

/* hdl/bss_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bss_dp: datapath of the bounded sorted set
// A row of entry cells with per-cell compares; removal shifts cells down,
// insertion shifts cells up, and the response register sits at the output.
// ----------------------------------------------------------------------------
module bss_dp #(
    parameter int CAPACITY  = bss_pkg::DEF_CAPACITY,
    parameter int KEY_BITS  = bss_pkg::DEF_KEY_BITS,
    parameter int RANK_BITS = bss_pkg::DEF_RANK_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bss_pkg::req_t                req_data,
    output bss_pkg::rsp_t                     rsp_data,
    input  wire logic                         cfg_we,
    input  wire logic [bss_pkg::LIMIT_W-1:0]  cfg_data,
    input  wire bss_pkg::cmd_t                cmd,
    output bss_pkg::sts_t                     sts
);
    import bss_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Captured request.
    logic [2:0]           op_act_reg;
    logic [KEY_BITS-1:0]  op_key_reg;
    logic [RANK_BITS-1:0] op_rank_reg;
    logic [3:0]           op_ofs_reg;

    // Entry cells.
    logic [KEY_BITS-1:0]  cell_key_reg  [CAPACITY];
    logic [RANK_BITS-1:0] cell_rank_reg [CAPACITY];
    logic [KEY_BITS-1:0]  cell_key_next [CAPACITY];
    logic [RANK_BITS-1:0] cell_rank_next[CAPACITY];

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg;

    logic [1:0]  res_status_reg, res_status_next;
    logic [3:0]  res_pos_reg, res_pos_next;
    logic [15:0] res_key_reg, res_key_next;
    logic [31:0] res_rank_reg, res_rank_next;
    rsp_t        rsp_reg;

    logic [31:0]          key_wide;
    logic [63:0]          rank_wide;
    logic [KEY_BITS-1:0]  key_in;
    logic [RANK_BITS-1:0] rank_in;

    logic [8:0] cnt9, lim9, ofs9;
    logic [CAPACITY-1:0] valid, match, pre_match, ge, gt, in_lim;
    logic any_match, any_ge, any_gt, full, accept;
    logic [3:0]  find_pos;
    logic [KEY_BITS-1:0]  sel_key;
    logic [RANK_BITS-1:0] sel_rank;
    logic [31:0] sel_key32;
    logic [63:0] sel_rank64;
    logic        ofs_ok;

    assign key_wide  = {16'b0, req_data.key};
    assign rank_wide = {32'b0, req_data.rank};
    assign key_in    = key_wide[KEY_BITS-1:0];
    assign rank_in   = rank_wide[RANK_BITS-1:0];

    assign sts.is_add = (op_act_reg == ACT_ADD);

    // Effective limit: zero acts as one, anything above the build size as the size.
    assign cnt9 = 9'(count_reg);
    assign ofs9 = {5'b0, op_ofs_reg};
    always_comb
    begin
        if (limit_reg == '0)
            lim9 = 9'd1;
        else if (9'(limit_reg) > 9'(CAPACITY))
            lim9 = 9'(CAPACITY);
        else
            lim9 = 9'(limit_reg);
    end

    // Per-cell compares. The list is sorted, so ge and gt are suffixes of the
    // valid cells.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid[i]  = (9'(i) < cnt9);
            in_lim[i] = (9'(i) < lim9);
            match[i]  = valid[i] && (cell_key_reg[i] == op_key_reg);
            ge[i]     = valid[i] && ($signed(op_rank_reg) <= $signed(cell_rank_reg[i]));
            gt[i]     = valid[i] && ($signed(op_rank_reg) < $signed(cell_rank_reg[i]));
        end
    end

    always_comb
    begin
        pre_match[0] = match[0];
        for (int i = 1; i < CAPACITY; i++)
            pre_match[i] = pre_match[i-1] | match[i];
    end

    assign any_match = |match;
    assign any_ge    = |ge;
    assign any_gt    = |gt;
    assign full      = (cnt9 >= lim9);
    assign accept    = !full || (|(gt & in_lim));

    // Position of the first cell whose rank is at least the request rank.
    always_comb
    begin
        find_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ge[i] && (i == 0 || !ge[(i == 0) ? 0 : i-1]))
                find_pos = find_pos | 4'(i);
        end
    end

    // Read port for the get action.
    always_comb
    begin
        sel_key  = '0;
        sel_rank = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ofs9 == 9'(i))
            begin
                sel_key  = cell_key_reg[i];
                sel_rank = cell_rank_reg[i];
            end
        end
    end
    assign sel_key32  = 32'(sel_key);
    assign sel_rank64 = 64'($signed(sel_rank));
    assign ofs_ok     = (ofs9 < cnt9) && (ofs9 < 9'(CAPACITY));

    // Cell and count updates.
    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_key_next[i]  = cell_key_reg[i];
            cell_rank_next[i] = cell_rank_reg[i];
        end
        if (cmd.step1)
        begin
            if ((op_act_reg == ACT_ADD || op_act_reg == ACT_DELETE) && any_match)
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    if (pre_match[i])
                    begin
                        cell_key_next[i]  = cell_key_reg[i+1];
                        cell_rank_next[i] = cell_rank_reg[i+1];
                    end
                end
                count_next = count_reg - 1'b1;
            end
            else if (op_act_reg == ACT_CLEAR)
            begin
                count_next = '0;
            end
        end
        else if (cmd.step2)
        begin
            if (accept)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (i > 0 && gt[(i == 0) ? 0 : i-1])
                    begin
                        cell_key_next[i]  = cell_key_reg[(i == 0) ? 0 : i-1];
                        cell_rank_next[i] = cell_rank_reg[(i == 0) ? 0 : i-1];
                    end
                    else if ((gt[i] && (i == 0 || !gt[(i == 0) ? 0 : i-1]))
                             || (!any_gt && 9'(i) == cnt9))
                    begin
                        cell_key_next[i]  = op_key_reg;
                        cell_rank_next[i] = op_rank_reg;
                    end
                end
            end
            // A full list ends at the limit whether the entry went in or not.
            if (full)
                count_next = CNT_W'(lim9);
            else
                count_next = count_reg + 1'b1;
        end
    end

    // Result fields of the first phase.
    always_comb
    begin
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_key_next    = res_key_reg;
        res_rank_next   = res_rank_reg;
        if (cmd.step1)
        begin
            res_status_next = ST_OK;
            res_pos_next    = '0;
            res_key_next    = '0;
            res_rank_next   = '0;
            case (op_act_reg)
                ACT_DELETE:
                begin
                    if (!any_match)
                        res_status_next = ST_NOT_FOUND;
                end
                ACT_FIND:
                begin
                    if (any_ge)
                        res_pos_next = find_pos;
                    else
                        res_status_next = ST_NOT_FOUND;
                end
                ACT_GET:
                begin
                    if (ofs_ok)
                    begin
                        res_key_next  = sel_key32[15:0];
                        res_rank_next = sel_rank64[31:0];
                    end
                    else
                    begin
                        res_status_next = ST_RANGE;
                    end
                end
                default:
                begin
                    res_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= LIMIT_W'(LIMIT_RESET);
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_act_reg  <= req_data.action;
            op_key_reg  <= key_in;
            op_rank_reg <= rank_in;
            op_ofs_reg  <= req_data.offset;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_key_reg[i]  <= cell_key_next[i];
            cell_rank_reg[i] <= cell_rank_next[i];
        end
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_key_reg    <= res_key_next;
        res_rank_reg   <= res_rank_next;
        if (cmd.load)
        begin
            rsp_reg.status   <= res_status_reg;
            rsp_reg.position <= res_pos_reg;
            rsp_reg.out_key  <= res_key_reg;
            rsp_reg.out_rank <= res_rank_reg;
            rsp_reg.count    <= 5'(count_reg);
        end
    end

    assign rsp_data = rsp_reg;

endmodule
`default_nettype wire
